/* src/rqbi_pkg.sv */
`default_nettype none

package rqbi_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int TASK_W        = 16;
  localparam int POS_W         = 5;
  localparam int LEN_W         = 5;

  typedef enum logic [1:0] {
    FUNC_ENQ    = 2'd0,
    FUNC_ENQ_AT = 2'd1,
    FUNC_DEQ    = 2'd2,
    FUNC_ERASE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [TASK_W-1:0]  task_id;
    logic               boosted;
    logic [POS_W-1:0]   position;
    logic               respect_boost;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [TASK_W-1:0]  out_task;
    logic [LEN_W-1:0]   length;
  } rsp_t;

endpackage

`default_nettype wire

/* src/rqbi_queue.sv */
`default_nettype none

module rqbi_queue
  import rqbi_pkg::*;
#(
  parameter  int DEPTH = DEFAULT_DEPTH,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire req_t          req,
  output rsp_t               result,
  output logic [CW-1:0]      occupancy
);

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [TASK_W-1:0] entries      [DEPTH];
  logic [TASK_W-1:0] entries_next [DEPTH];
  logic [CW-1:0]     occupancy_next;
  logic              full;
  logic              empty;
  logic [PW-1:0]     pos_ext;
  logic [PW-1:0]     occ_ext;
  logic [CW-1:0]     ins_pos;
  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  is_tail;
  logic              tail_hit;
  logic              found;
  logic [CW-1:0]     first_idx;
  logic              do_ins;
  logic              do_rem;
  logic [CW-1:0]     idx;
  status_t           res_status;
  logic [TASK_W-1:0] res_task;

  assign full    = (occupancy == CW'(DEPTH));
  assign empty   = (occupancy == '0);
  assign pos_ext = PW'(req.position);
  assign occ_ext = PW'(occupancy);
  assign ins_pos = (pos_ext > occ_ext) ? occupancy : CW'(req.position);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i]   = (entries[i] == req.task_id) && (CW'(i) < occupancy);
      is_tail[i] = (CW'(i + 1) == occupancy);
    end
  end

  assign tail_hit = |(match & is_tail);

  always_comb begin
    found     = 1'b0;
    first_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i] && !found) begin
        found     = 1'b1;
        first_idx = CW'(i);
      end
    end
  end

  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    idx        = '0;
    res_status = ST_OK;
    res_task   = '0;
    unique case (req.func)
      FUNC_ENQ: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          idx    = req.boosted ? '0 : occupancy;
        end
      end
      FUNC_ENQ_AT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          idx    = (req.respect_boost && req.boosted) ? '0 : ins_pos;
        end
      end
      FUNC_DEQ: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_task = entries[0];
          do_rem   = 1'b1;
        end
      end
      FUNC_ERASE: begin
        if (found) begin
          do_rem = 1'b1;
          idx    = tail_hit ? CW'(occupancy - 1'b1) : first_idx;
        end else begin
          res_status = ST_MISSING;
        end
      end
      default: begin
        res_status = ST_MISSING;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_next[i] = entries[i];
      if (do_ins) begin
        if (CW'(i) > idx) begin
          entries_next[i] = entries[(i + DEPTH - 1) % DEPTH];
        end else if (CW'(i) == idx) begin
          entries_next[i] = req.task_id;
        end
      end else if (do_rem) begin
        if (CW'(i) >= idx) begin
          entries_next[i] = entries[(i + 1) % DEPTH];
        end
      end
    end
  end

  always_comb begin
    occupancy_next = occupancy;
    if (do_ins) begin
      occupancy_next = CW'(occupancy + 1'b1);
    end else if (do_rem) begin
      occupancy_next = CW'(occupancy - 1'b1);
    end
  end

  assign result = '{status: res_status, out_task: res_task, length: LEN_W'(occupancy_next)};

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < DEPTH; i++) begin
        entries[i] <= entries_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (fire) begin
      occupancy <= occupancy_next;
    end
  end

endmodule

`default_nettype wire

/* src/run_queue_boost_insert_core.sv */
// Run queue of task identifiers with head, tail and positional insertion.
// Each result is registered into a two-entry result buffer, which keeps input
// flowing. Throughput: one item per cycle while that buffer is not full; the
// whole operation is one pass over the shift-register slots.
// Reset (synchronous, active high) empties the queue and the result buffer.
`default_nettype none

module run_queue_boost_insert_core
  import rqbi_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic          push;
  logic          pop;
  rsp_t          result;
  logic [CW-1:0] occupancy;
  rsp_t          slot0;
  rsp_t          slot1;
  logic [1:0]    cnt;
  logic [1:0]    cnt_next;
  logic [1:0]    target;

  assign req_ready = (cnt != 2'd2);
  assign push      = req_valid && req_ready;
  assign rsp_valid = (cnt != 2'd0);
  assign pop       = rsp_valid && rsp_ready;
  assign rsp       = slot0;

  rqbi_queue #(
    .DEPTH(DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .fire      (push),
    .req       (req),
    .result    (result),
    .occupancy (occupancy)
  );

  assign target   = cnt - {1'b0, pop};
  assign cnt_next = cnt + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push && (target == 2'd0)) begin
      slot0 <= result;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (push && (target != 2'd0)) begin
      slot1 <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result buffer count out of range");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    push && (result.status == ST_FULL) |-> occupancy == CW'(DEPTH))
    else $error("full status reported on a queue that is not full");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    push |=> (occupancy == $past(occupancy)) ||
             (occupancy == CW'($past(occupancy) + 1'b1)) ||
             (CW'(occupancy + 1'b1) == $past(occupancy)))
    else $error("occupancy moved by more than one");

  a_occ_idle: assert property (@(posedge clk) disable iff (rst)
    !push |=> $stable(occupancy))
    else $error("occupancy changed without an item");

endmodule

`default_nettype wire

/* dv/run_queue_boost_insert_core_test.sv */
`default_nettype none

module run_queue_boost_insert_core_test;
  import rqbi_pkg::*;

  localparam int DEPTH       = DEFAULT_DEPTH;
  localparam int WAIT_MAX    = 11;
  localparam int STALL_LIMIT = 1000;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  logic [TASK_W-1:0] model_slots[$];
  rsp_t              pending_results[$];

  int mismatch_count = 0;
  int idle_cycles    = 0;
  int send_streak    = 0;
  int recv_streak    = 0;
  int items_sent     = 0;
  int func_count[4]  = '{default: 0};
  int status_count[4] = '{default: 0};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  run_queue_boost_insert_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // Most waits are random, but now and then a stretch of back-to-back items follows.
  function automatic int draw_wait(ref int streak);
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      streak = $urandom_range(8, 24);
      return 0;
    end
    return $urandom_range(0, WAIT_MAX);
  endfunction

  function automatic rsp_t apply_run_queue_op(req_t op);
    rsp_t res;
    int   at;
    int   found;
    int   fill;
    res.status   = ST_OK;
    res.out_task = '0;
    fill         = model_slots.size();
    found        = -1;
    case (op.func)
      FUNC_ENQ, FUNC_ENQ_AT: begin
        if (fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (op.func == FUNC_ENQ) begin
            at = op.boosted ? 0 : fill;
          end else if (op.respect_boost && op.boosted) begin
            at = 0;
          end else begin
            at = (int'(op.position) > fill) ? fill : int'(op.position);
          end
          model_slots.insert(at, op.task_id);
        end
      end
      FUNC_DEQ: begin
        if (fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_task = model_slots[0];
          model_slots.delete(0);
        end
      end
      default: begin
        res.status = ST_MISSING;
        if (fill > 0) begin
          if (model_slots[fill-1] == op.task_id) begin
            found = fill - 1;
          end else begin
            for (int i = 0; i + 1 < fill; i++) begin
              if (found < 0 && model_slots[i] == op.task_id) begin
                found = i;
              end
            end
          end
        end
        if (found >= 0) begin
          model_slots.delete(found);
          res.status = ST_OK;
        end
      end
    endcase
    res.length = LEN_W'(model_slots.size());
    return res;
  endfunction

  function automatic req_t make_op(func_t f, logic [TASK_W-1:0] id, logic boost,
                                   logic [POS_W-1:0] pos, logic respect);
    req_t op;
    op.func          = f;
    op.task_id       = id;
    op.boosted       = boost;
    op.position      = pos;
    op.respect_boost = respect;
    return op;
  endfunction

  function automatic req_t random_op(int insert_pct);
    req_t op;
    int   pick;
    int   fill;
    fill             = model_slots.size();
    op.task_id       = TASK_W'($urandom);
    op.boosted       = 1'($urandom_range(0, 1));
    op.respect_boost = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      op.position = POS_W'($urandom);
    end else begin
      op.position = POS_W'($urandom_range(0, fill));
    end
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) begin
      op.func = ($urandom_range(0, 1) == 1) ? FUNC_ENQ_AT : FUNC_ENQ;
      if (fill > 0 && $urandom_range(0, 4) == 0) begin
        op.task_id = model_slots[$urandom_range(0, fill - 1)];
      end
    end else if (pick < insert_pct + (100 - insert_pct) / 2) begin
      op.func = FUNC_DEQ;
    end else begin
      op.func = FUNC_ERASE;
      if (fill > 0 && $urandom_range(0, 3) != 0) begin
        op.task_id = model_slots[$urandom_range(0, fill - 1)];
      end
    end
    return op;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_item(req_t item);
    int gap;
    gap = draw_wait(send_streak);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       = item;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic park_sender();
    req_valid = 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        pending_results.insert(pending_results.size(), apply_run_queue_op(req));
        func_count[int'(req.func)]++;
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no item outstanding, status", int'(rsp.status), 0);
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          status_count[int'(want.status)]++;
          if (rsp.status !== want.status) begin
            report_mismatch("status", int'(rsp.status), int'(want.status));
          end
          if (rsp.out_task !== want.out_task) begin
            report_mismatch("out_task", int'(rsp.out_task), int'(want.out_task));
          end
          if (rsp.length !== want.length) begin
            report_mismatch("length", int'(rsp.length), int'(want.length));
          end
        end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : result_sink
    int stall;
    wait (!rst);
    forever begin
      stall = draw_wait(recv_streak);
      if (stall > 0) begin
        rsp_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    wait (!rst);
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("TB_ERROR");
    $finish;
  end

  task automatic test_empty_queue();
    send_item(make_op(FUNC_DEQ, 16'h0000, 1'b0, 5'd0, 1'b0));
    send_item(make_op(FUNC_ERASE, 16'hFFFF, 1'b1, 5'd31, 1'b1));
  endtask

  task automatic test_insert_modes();
    send_item(make_op(FUNC_ENQ, 16'hFFFF, 1'b0, 5'd0, 1'b0));
    send_item(make_op(FUNC_ENQ, 16'h0000, 1'b1, 5'd0, 1'b0));
    send_item(make_op(FUNC_ENQ_AT, 16'h1234, 1'b0, 5'd1, 1'b0));
    send_item(make_op(FUNC_ENQ_AT, 16'hABCD, 1'b0, 5'd31, 1'b1));
    send_item(make_op(FUNC_ENQ_AT, 16'h5555, 1'b1, 5'd3, 1'b1));
    send_item(make_op(FUNC_ENQ_AT, 16'h8001, 1'b1, 5'd16, 1'b0));
    send_item(make_op(FUNC_ENQ_AT, 16'hAAAA, 1'b0, 5'd2, 1'b1));
  endtask

  task automatic test_erase_and_duplicates();
    send_item(make_op(FUNC_ENQ, 16'h0F0F, 1'b0, 5'd0, 1'b0));
    send_item(make_op(FUNC_ENQ_AT, 16'h0F0F, 1'b0, 5'd0, 1'b0));
    send_item(make_op(FUNC_ERASE, 16'h0F0F, 1'b0, 5'd0, 1'b0));
    send_item(make_op(FUNC_ERASE, 16'h0F0F, 1'b0, 5'd0, 1'b0));
    send_item(make_op(FUNC_ERASE, 16'h1234, 1'b0, 5'd0, 1'b0));
    send_item(make_op(FUNC_ERASE, 16'h7777, 1'b0, 5'd0, 1'b0));
    send_item(make_op(FUNC_DEQ, 16'h0000, 1'b0, 5'd0, 1'b0));
    send_item(make_op(FUNC_DEQ, 16'h0000, 1'b0, 5'd0, 1'b0));
    send_item(make_op(FUNC_ERASE, 16'hFFFF, 1'b0, 5'd0, 1'b0));
  endtask

  // The sender holds back until the block has returned every outstanding result.
  task automatic test_drain_pause();
    park_sender();
    wait_for_results();
  endtask

  task automatic test_random_traffic(int count, int insert_pct);
    repeat (count) send_item(random_op(insert_pct));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_queue();
    test_insert_modes();
    test_erase_and_duplicates();
    test_drain_pause();
    test_random_traffic(250, 75);
    test_drain_pause();
    test_random_traffic(240, 50);
    test_random_traffic(240, 25);

    park_sender();
    wait_for_results();
    repeat (4) @(posedge clk);

    $display("Sent %0d items: %0d enqueue, %0d enqueue-at, %0d dequeue, %0d erase.",
             items_sent, func_count[0], func_count[1], func_count[2], func_count[3]);
    $display("Results: %0d ok, %0d empty, %0d full, %0d not found; %0d mismatches.",
             status_count[0], status_count[1], status_count[2], status_count[3],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
